FILE: src/bpr_pkg.sv
package bpr_pkg;

    typedef struct packed {
        logic [2:0]         action;
        logic [9:0]         user_index;
        logic [11:0]        pos_item;
        logic [11:0]        neg_item;
        logic [3:0]         factor_index;
        logic signed [15:0] write_value;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] read_value;
        logic signed [15:0] score;
        logic [15:0]        weight;
    } result_t;

    // Element pass control from the sequencer into the update pipe
    typedef struct packed {
        logic       valid;
        logic [1:0] phase;
    } issue_t;

    // Write-back strobes from the update pipe to the factor memories
    typedef struct packed {
        logic user_we;
        logic item_we;
    } wb_t;

    localparam logic [2:0] ACT_WR_USER = 3'd0;
    localparam logic [2:0] ACT_WR_ITEM = 3'd1;
    localparam logic [2:0] ACT_RD_USER = 3'd2;
    localparam logic [2:0] ACT_RD_ITEM = 3'd3;
    localparam logic [2:0] ACT_TRAIN   = 3'd4;

    localparam logic [1:0] PH_DOT  = 2'd0;
    localparam logic [1:0] PH_USER = 2'd1;
    localparam logic [1:0] PH_POS  = 2'd2;
    localparam logic [1:0] PH_NEG  = 2'd3;

    localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
    localparam logic [1:0] CFG_USER_REG   = 2'd1;
    localparam logic [1:0] CFG_ITEM_REG   = 2'd2;

    localparam logic [15:0] LEARN_RATE_RST = 16'd66;
    localparam logic [15:0] USER_REG_RST   = 16'd655;
    localparam logic [15:0] ITEM_REG_RST   = 16'd655;

    typedef logic [15:0] wtab_t [256];

    // Logistic weight table, built at elaboration; long division by subtraction
    function automatic wtab_t build_wtab();
        wtab_t       tab;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        logic [63:0] lo;
        e = 64'd17309782;
        for (int j = 0; j < 128; j++)
        begin
            den = (64'd1 << 24) + e;
            num = (64'd1 << 40) + (den >> 1);
            rem = '0;
            q   = '0;
            for (int i = 63; i >= 0; i--)
            begin
                rem = {rem[62:0], num[i]};
                if (rem >= den)
                begin
                    rem  = rem - den;
                    q[i] = 1'b1;
                end
            end
            lo = 64'd65536 - q;
            if (lo > 64'd65535)
            begin
                lo = 64'd65535;
            end
            if (q > 64'd65535)
            begin
                q = 64'd65535;
            end
            tab[128 + j] = q[15:0];
            tab[127 - j] = lo[15:0];
            e = (e * 64'd17859253 + (64'd1 << 23)) >> 24;
        end
        return tab;
    endfunction

    localparam wtab_t WEIGHT_TAB = build_wtab();

endpackage

FILE: src/bpr_factor_sgd_update_unit.sv
// BPR factor update engine. Holds a user table and an item table of signed Q3.12
// latent factors in synchronous RAM (no reset of contents: write every element
// before it is read or trained on). An item is taken on start while busy is low.
// An element write answers in the cycle after it is taken, an element read passes
// through the read state first; the result strobe (done) lasts one cycle, with no way to hold it off.
// A training triple streams the three rows through a three-stage multiply pipe
// one element per cycle in four passes (score, user row, positive row, negative
// row), draining the pipe between passes so each pass sees the previous writes.
// Rows out of range make a train a no-op with zero score and weight.
module bpr_factor_sgd_update_unit #(
    parameter int NUM_USERS = 1024,
    parameter int NUM_ITEMS = 4096,
    parameter int FACTORS   = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bpr_pkg::cmd_t     cmd,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [15:0]       cfg_data,
    output logic              done,
    output bpr_pkg::result_t  result
);

    localparam int KW  = (FACTORS > 1) ? $clog2(FACTORS) : 1;
    localparam int DW  = 35 + KW;
    localparam int UD  = NUM_USERS * FACTORS;
    localparam int ID  = NUM_ITEMS * FACTORS;
    localparam int UA  = (UD > 1) ? $clog2(UD) : 1;
    localparam int IA  = (ID > 1) ? $clog2(ID) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_ISSUE  = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_SCORE  = 3'd4;
    localparam logic [2:0] ST_WEIGHT = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [UA-1:0]     ubase_reg, ubase_next;
    logic [IA-1:0]     pbase_reg, pbase_next;
    logic [IA-1:0]     nbase_reg, nbase_next;
    logic              rd_user_reg, rd_user_next;
    logic              rd_ok_reg, rd_ok_next;
    logic signed [15:0] score_reg, score_next;
    logic [15:0]       weight_reg, weight_next;
    logic [15:0]       learn_rate_reg, user_reg_reg, item_reg_reg;
    logic              done_reg, done_next;
    bpr_pkg::result_t  result_reg, result_next;

    logic              u_ok, p_ok, n_ok, f_ok;
    logic [UA-1:0]     u_elem;
    logic [IA-1:0]     p_elem;
    logic              accept;

    logic              user_we, item_we;
    logic [UA-1:0]     user_waddr, user_raddr;
    logic [IA-1:0]     item_waddr, item_raddr_a, item_raddr_b;
    logic [15:0]       user_wdata, item_wdata;
    logic [15:0]       u_q, p_q, n_q;

    bpr_pkg::issue_t   issue;
    bpr_pkg::wb_t      wb;
    logic [KW-1:0]     wb_k;
    logic [15:0]       wb_data;
    logic signed [DW-1:0] dot;
    logic signed [DW-1:0] dot_round;
    logic signed [DW-13:0] dot_shift;
    logic              pipe_busy;
    logic              dot_clear;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    assign u_ok   = 32'(cmd.user_index) < NUM_USERS;
    assign p_ok   = 32'(cmd.pos_item) < NUM_ITEMS;
    assign n_ok   = 32'(cmd.neg_item) < NUM_ITEMS;
    assign f_ok   = 32'(cmd.factor_index) < FACTORS;
    assign u_elem = UA'(32'(cmd.user_index) * FACTORS + 32'(cmd.factor_index));
    assign p_elem = IA'(32'(cmd.pos_item) * FACTORS + 32'(cmd.factor_index));

    // Memory ports: commands drive them while idle, the pipe otherwise
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            user_we      = accept && cmd.action == bpr_pkg::ACT_WR_USER && u_ok && f_ok;
            item_we      = accept && cmd.action == bpr_pkg::ACT_WR_ITEM && p_ok && f_ok;
            user_waddr   = u_elem;
            item_waddr   = p_elem;
            user_wdata   = cmd.write_value;
            item_wdata   = cmd.write_value;
            user_raddr   = u_elem;
            item_raddr_a = p_elem;
            item_raddr_b = p_elem;
        end
        else
        begin
            user_we      = wb.user_we;
            item_we      = wb.item_we;
            user_waddr   = ubase_reg + UA'(wb_k);
            item_waddr   = ((phase_reg == bpr_pkg::PH_NEG) ? nbase_reg : pbase_reg)
                           + IA'(wb_k);
            user_wdata   = wb_data;
            item_wdata   = wb_data;
            user_raddr   = ubase_reg + UA'(k_reg);
            item_raddr_a = pbase_reg + IA'(k_reg);
            item_raddr_b = nbase_reg + IA'(k_reg);
        end
    end

    assign issue.valid = (state_reg == ST_ISSUE);
    assign issue.phase = phase_reg;
    assign dot_clear   = accept && cmd.action == bpr_pkg::ACT_TRAIN;

    // Round the Q.24 dot product to Q3.12 (floor after adding half)
    assign dot_round = dot + DW'(2048);
    assign dot_shift = dot_round[DW-1:12];

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        k_next       = k_reg;
        ubase_next   = ubase_reg;
        pbase_next   = pbase_reg;
        nbase_next   = nbase_reg;
        rd_user_next = rd_user_reg;
        rd_ok_next   = rd_ok_reg;
        score_next   = score_reg;
        weight_next  = weight_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next = '0;
                    case (cmd.action) inside
                        bpr_pkg::ACT_RD_USER, bpr_pkg::ACT_RD_ITEM:
                        begin
                            rd_user_next = (cmd.action == bpr_pkg::ACT_RD_USER);
                            rd_ok_next   = f_ok && ((cmd.action == bpr_pkg::ACT_RD_USER)
                                                    ? u_ok : p_ok);
                            state_next   = ST_READ;
                        end
                        bpr_pkg::ACT_TRAIN:
                        begin
                            if (u_ok && p_ok && n_ok)
                            begin
                                ubase_next = UA'(32'(cmd.user_index) * FACTORS);
                                pbase_next = IA'(32'(cmd.pos_item) * FACTORS);
                                nbase_next = IA'(32'(cmd.neg_item) * FACTORS);
                                phase_next = bpr_pkg::PH_DOT;
                                k_next     = '0;
                                state_next = ST_ISSUE;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            // writes and unused codes answer at once with zeros
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (rd_ok_reg)
                begin
                    result_next.read_value = rd_user_reg ? u_q : p_q;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ISSUE:
            begin
                // advance one element a cycle; drain after the last
                k_next = k_reg + KW'(1);
                if (k_reg == KW'(FACTORS - 1))
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    case (phase_reg)
                        bpr_pkg::PH_DOT:
                        begin
                            state_next = ST_SCORE;
                        end
                        bpr_pkg::PH_USER:
                        begin
                            phase_next = bpr_pkg::PH_POS;
                            state_next = ST_ISSUE;
                        end
                        bpr_pkg::PH_POS:
                        begin
                            phase_next = bpr_pkg::PH_NEG;
                            state_next = ST_ISSUE;
                        end
                        default:
                        begin
                            result_next.score  = score_reg;
                            result_next.weight = weight_reg;
                            done_next          = 1'b1;
                            state_next         = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCORE:
            begin
                if (dot_shift > (DW-12)'(32767))
                begin
                    score_next = 16'sh7fff;
                end
                else if (dot_shift < -(DW-12)'(32768))
                begin
                    score_next = 16'sh8000;
                end
                else
                begin
                    score_next = dot_shift[15:0];
                end
                state_next = ST_WEIGHT;
            end
            ST_WEIGHT:
            begin
                // table entry is (score + 32768) >> 8
                weight_next = bpr_pkg::WEIGHT_TAB[{~score_reg[15], score_reg[14:8]}];
                phase_next  = bpr_pkg::PH_USER;
                state_next  = ST_ISSUE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            learn_rate_reg <= bpr_pkg::LEARN_RATE_RST;
            user_reg_reg   <= bpr_pkg::USER_REG_RST;
            item_reg_reg   <= bpr_pkg::ITEM_REG_RST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    bpr_pkg::CFG_LEARN_RATE: learn_rate_reg <= cfg_data;
                    bpr_pkg::CFG_USER_REG:   user_reg_reg   <= cfg_data;
                    bpr_pkg::CFG_ITEM_REG:   item_reg_reg   <= cfg_data;
                    default:
                    begin
                        // drop writes to unknown indexes
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg   <= phase_next;
        k_reg       <= k_next;
        ubase_reg   <= ubase_next;
        pbase_reg   <= pbase_next;
        nbase_reg   <= nbase_next;
        rd_user_reg <= rd_user_next;
        rd_ok_reg   <= rd_ok_next;
        score_reg   <= score_next;
        weight_reg  <= weight_next;
        result_reg  <= result_next;
    end

    bpr_user_mem #(
        .DEPTH (UD),
        .AW    (UA)
    ) u_user_mem (
        .clk   (clk),
        .we    (user_we),
        .waddr (user_waddr),
        .wdata (user_wdata),
        .raddr (user_raddr),
        .rdata (u_q)
    );

    bpr_item_mem #(
        .DEPTH (ID),
        .AW    (IA)
    ) u_item_mem (
        .clk     (clk),
        .we      (item_we),
        .waddr   (item_waddr),
        .wdata   (item_wdata),
        .raddr_a (item_raddr_a),
        .raddr_b (item_raddr_b),
        .rdata_a (p_q),
        .rdata_b (n_q)
    );

    bpr_update_pipe #(
        .KW (KW),
        .DW (DW)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .issue_k    (k_reg),
        .dot_clear  (dot_clear),
        .u_q        (u_q),
        .p_q        (p_q),
        .n_q        (n_q),
        .weight     (weight_reg),
        .learn_rate (learn_rate_reg),
        .user_reg   (user_reg_reg),
        .item_reg   (item_reg_reg),
        .wb         (wb),
        .wb_k       (wb_k),
        .wb_data    (wb_data),
        .dot        (dot),
        .busy       (pipe_busy)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: src/bpr_user_mem.sv
module bpr_user_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bpr_item_mem.sv
module bpr_item_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [15:0]   rdata_a,
    output logic [15:0]   rdata_b
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_a_reg;
    logic [15:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: src/bpr_update_pipe.sv
module bpr_update_pipe #(
    parameter int KW = 4,
    parameter int DW = 39
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpr_pkg::issue_t      issue,
    input  logic [KW-1:0]        issue_k,
    input  logic                 dot_clear,
    input  logic signed [15:0]   u_q,
    input  logic signed [15:0]   p_q,
    input  logic signed [15:0]   n_q,
    input  logic [15:0]          weight,
    input  logic [15:0]          learn_rate,
    input  logic [15:0]          user_reg,
    input  logic [15:0]          item_reg,
    output bpr_pkg::wb_t         wb,
    output logic [KW-1:0]        wb_k,
    output logic [15:0]          wb_data,
    output logic signed [DW-1:0] dot,
    output logic                 busy
);

    bpr_pkg::issue_t    s1_reg;
    bpr_pkg::issue_t    s2_reg;
    bpr_pkg::issue_t    s3_reg;
    logic [KW-1:0]      k1_reg;
    logic [KW-1:0]      k2_reg;
    logic [KW-1:0]      k3_reg;
    logic signed [33:0] a2_reg;
    logic signed [33:0] a2_next;
    logic signed [32:0] b2_reg;
    logic signed [32:0] b2_next;
    logic signed [15:0] old2_reg;
    logic signed [15:0] old2_next;
    logic signed [15:0] old3_reg;
    logic signed [51:0] m3_reg;
    logic signed [51:0] m3_next;
    logic signed [DW-1:0] dot_reg;
    logic signed [DW-1:0] dot_next;

    logic signed [16:0] diff;
    logic signed [16:0] op1;
    logic signed [16:0] op2;
    logic signed [16:0] regw;
    logic signed [34:0] t2;
    logic signed [51:0] round3;
    logic signed [19:0] delta;
    logic signed [20:0] sum3;
    logic signed [15:0] new3;

    // Stage 1: memory data is here; form both products
    always_comb
    begin
        diff = {p_q[15], p_q} - {n_q[15], n_q};
        if (s1_reg.phase == bpr_pkg::PH_DOT)
        begin
            op1 = {u_q[15], u_q};
        end
        else
        begin
            op1 = signed'({1'b0, weight});
        end
        if (s1_reg.phase == bpr_pkg::PH_DOT || s1_reg.phase == bpr_pkg::PH_USER)
        begin
            op2 = diff;
        end
        else
        begin
            op2 = {u_q[15], u_q};
        end
        if (s1_reg.phase == bpr_pkg::PH_USER)
        begin
            old2_next = u_q;
            regw      = signed'({1'b0, user_reg});
        end
        else if (s1_reg.phase == bpr_pkg::PH_POS)
        begin
            old2_next = p_q;
            regw      = signed'({1'b0, item_reg});
        end
        else
        begin
            old2_next = n_q;
            regw      = signed'({1'b0, item_reg});
        end
        a2_next = 34'(op1) * 34'(op2);
        b2_next = 33'(regw) * 33'(old2_next);
    end

    // Stage 2: gradient term, scaled by the learning rate; accumulate the score
    always_comb
    begin
        if (s2_reg.phase == bpr_pkg::PH_NEG)
        begin
            t2 = -35'(a2_reg) - 35'(b2_reg);
        end
        else
        begin
            t2 = 35'(a2_reg) - 35'(b2_reg);
        end
        m3_next = 52'(signed'({1'b0, learn_rate})) * 52'(t2);
        dot_next = dot_reg;
        if (dot_clear)
        begin
            dot_next = '0;
        end
        else if (s2_reg.valid && s2_reg.phase == bpr_pkg::PH_DOT)
        begin
            dot_next = dot_reg + DW'(a2_reg);
        end
    end

    // Stage 3: round, add, saturate, write back
    always_comb
    begin
        round3 = m3_reg + 52'sd2147483648;
        delta  = round3[51:32];
        sum3   = 21'(old3_reg) + 21'(delta);
        if (sum3 > 21'sd32767)
        begin
            new3 = 16'sh7fff;
        end
        else if (sum3 < -21'sd32768)
        begin
            new3 = 16'sh8000;
        end
        else
        begin
            new3 = sum3[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else
        begin
            s1_reg <= issue;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg   <= issue_k;
        k2_reg   <= k1_reg;
        k3_reg   <= k2_reg;
        a2_reg   <= a2_next;
        b2_reg   <= b2_next;
        old2_reg <= old2_next;
        old3_reg <= old2_reg;
        m3_reg   <= m3_next;
        dot_reg  <= dot_next;
    end

    assign wb.user_we = s3_reg.valid && s3_reg.phase == bpr_pkg::PH_USER;
    assign wb.item_we = s3_reg.valid
                        && (s3_reg.phase == bpr_pkg::PH_POS || s3_reg.phase == bpr_pkg::PH_NEG);
    assign wb_k    = k3_reg;
    assign wb_data = new3;
    assign dot     = dot_reg;
    assign busy    = s1_reg.valid || s2_reg.valid || s3_reg.valid;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_USERS  = 1024;
    localparam int N_ITEMS  = 4096;
    localparam int N_FACT   = 16;
    localparam int IDLE_LIMIT = 3000;
    localparam logic [2:0] ACT_LAST = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    bpr_pkg::cmd_t      cmd;
    logic               cfg_we;
    logic [1:0]         cfg_addr;
    logic [15:0]        cfg_data;
    logic               done;
    bpr_pkg::result_t   result;

    bpr_factor_sgd_update_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    // Mirror of the factor tables and registers, advanced as items are accepted
    logic signed [15:0] user_rows [N_USERS*N_FACT];
    logic signed [15:0] item_rows [N_ITEMS*N_FACT];
    logic [15:0]        rate_q16;
    logic [15:0]        user_decay;
    logic [15:0]        item_decay;
    logic [15:0]        logistic_lut [256];

    bpr_pkg::cmd_t    pending_cmds [$];
    bpr_pkg::result_t expected_results [$];

    int  mismatches;
    int  idle_cycles;
    int  gap_left;
    bit  calm;

    // Rows used by reads and trains; all of them are filled before first use
    int user_pool [6] = '{0, 1, 2, 341, 682, 1023};
    int item_pool [8] = '{0, 1, 2, 3, 1365, 2730, 4094, 4095};

    always #6 clk = ~clk;

    function automatic void build_logistic_lut();
        longint unsigned e;
        longint unsigned den;
        longint unsigned w;
        longint unsigned lo;
        e = 64'd17309782;
        for (int j = 0; j < 128; j++)
        begin
            den = (64'd1 << 24) + e;
            w   = ((64'd1 << 40) + (den >> 1)) / den;
            lo  = 64'd65536 - w;
            if (lo > 64'd65535)
                lo = 64'd65535;
            if (w > 64'd65535)
                w = 64'd65535;
            logistic_lut[128 + j] = w[15:0];
            logistic_lut[127 - j] = lo[15:0];
            e = (e * 64'd17859253 + (64'd1 << 23)) >> 24;
        end
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // One SGD nudge: scale the Q.28 gradient by the rate, round, saturate
    function automatic logic signed [15:0] nudge(longint old_v, longint grad);
        longint delta;
        delta = (longint'(rate_q16) * grad + (64'sd1 <<< 31)) >>> 32;
        return 16'(clamp16(old_v + delta));
    endfunction

    // Apply one command to the mirrored tables and return the result it yields
    function automatic bpr_pkg::result_t apply_command(bpr_pkg::cmd_t c);
        bpr_pkg::result_t r;
        longint  dot;
        longint  d;
        longint  sc;
        longint  w;
        longint  u_new;
        int      ub;
        int      pb;
        int      nb;
        r  = '0;
        ub = int'(c.user_index) * N_FACT;
        pb = int'(c.pos_item) * N_FACT;
        nb = int'(c.neg_item) * N_FACT;
        case (c.action)
            bpr_pkg::ACT_WR_USER: user_rows[ub + c.factor_index] = c.write_value;
            bpr_pkg::ACT_WR_ITEM: item_rows[pb + c.factor_index] = c.write_value;
            bpr_pkg::ACT_RD_USER: r.read_value = user_rows[ub + c.factor_index];
            bpr_pkg::ACT_RD_ITEM: r.read_value = item_rows[pb + c.factor_index];
            bpr_pkg::ACT_TRAIN:
            begin
                dot = 0;
                for (int k = 0; k < N_FACT; k++)
                begin
                    d   = longint'(item_rows[pb + k]) - longint'(item_rows[nb + k]);
                    dot += longint'(user_rows[ub + k]) * d;
                end
                sc = clamp16((dot + 2048) >>> 12);
                w  = longint'(logistic_lut[int'((sc + 32768) >> 8) & 255]);
                for (int k = 0; k < N_FACT; k++)
                begin
                    d = longint'(item_rows[pb + k]) - longint'(item_rows[nb + k]);
                    user_rows[ub + k] = nudge(user_rows[ub + k],
                        w * d - longint'(user_decay) * longint'(user_rows[ub + k]));
                end
                for (int k = 0; k < N_FACT; k++)
                begin
                    u_new = user_rows[ub + k];
                    item_rows[pb + k] = nudge(item_rows[pb + k],
                        w * u_new - longint'(item_decay) * longint'(item_rows[pb + k]));
                end
                // Negative row reads back the positive write when both rows match
                for (int k = 0; k < N_FACT; k++)
                begin
                    u_new = user_rows[ub + k];
                    item_rows[nb + k] = nudge(item_rows[nb + k],
                        -w * u_new - longint'(item_decay) * longint'(item_rows[nb + k]));
                end
                r.score  = 16'(sc);
                r.weight = 16'(w);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            return 16'($urandom_range(0, 4095) - 2048);
        if (sel < 90)
            return 16'($urandom);
        return sel[0] ? 16'sh7fff : 16'sh8000;
    endfunction

    function automatic bpr_pkg::cmd_t random_cmd();
        bpr_pkg::cmd_t c;
        int   sel;
        c   = bpr_pkg::cmd_t'($bits(bpr_pkg::cmd_t)'({$urandom, $urandom}));
        sel = $urandom_range(0, 99);
        c.user_index = 10'(user_pool[$urandom_range(0, 5)]);
        c.pos_item   = 12'(item_pool[$urandom_range(0, 7)]);
        if (sel < 45)
        begin
            c.action = bpr_pkg::ACT_TRAIN;
            c.neg_item = ($urandom_range(0, 6) == 0) ? c.pos_item
                                                     : 12'(item_pool[$urandom_range(0, 7)]);
        end
        else if (sel < 55)
            c.action = bpr_pkg::ACT_RD_USER;
        else if (sel < 65)
            c.action = bpr_pkg::ACT_RD_ITEM;
        else if (sel < 77)
        begin
            c.action      = bpr_pkg::ACT_WR_USER;
            c.write_value = pick_value();
            // Some writes land on rows that are never read back
            if ($urandom_range(0, 3) == 0)
                c.user_index = 10'($urandom);
        end
        else if (sel < 92)
        begin
            c.action      = bpr_pkg::ACT_WR_ITEM;
            c.write_value = pick_value();
            if ($urandom_range(0, 3) == 0)
                c.pos_item = 12'($urandom);
        end
        else
            c.action = 3'($urandom_range(int'(bpr_pkg::ACT_TRAIN) + 1, int'(ACT_LAST)));
        return c;
    endfunction

    function automatic bpr_pkg::cmd_t make_cmd(logic [2:0] act, int u, int p, int n, int f,
                                               logic signed [15:0] v);
        bpr_pkg::cmd_t c;
        c.action       = act;
        c.user_index   = 10'(u);
        c.pos_item     = 12'(p);
        c.neg_item     = 12'(n);
        c.factor_index = 4'(f);
        c.write_value  = v;
        return c;
    endfunction

    // Append an item to the pending queue
    function automatic void queue_cmd(bpr_pkg::cmd_t c);
        pending_cmds = {pending_cmds, c};
    endfunction

    // Driver: present the next pending item after its drawn gap; predict on accept
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_results = {expected_results, apply_command(cmd)};
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd      <= pending_cmds.pop_front();
                    start    <= 1'b1;
                    gap_left <= calm ? 0 : $urandom_range(0, 14);
                    // Toggle between stalling and back-to-back stretches
                    if ($urandom_range(0, 39) == 0)
                        calm <= ~calm;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: check every strobed result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                mismatches++;
            end
            else
            begin
                bpr_pkg::result_t exp_r;
                exp_r = expected_results.pop_front();
                if (exp_r.read_value !== result.read_value)
                begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, exp_r.read_value, result.read_value);
                    mismatches++;
                end
                if (exp_r.score !== result.score)
                begin
                    $display("%0t: score expected %0d actual %0d",
                             $time, exp_r.score, result.score);
                    mismatches++;
                end
                if (exp_r.weight !== result.weight)
                begin
                    $display("%0t: weight expected %0d actual %0d",
                             $time, exp_r.weight, result.weight);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted item, result or register write
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Hold until every item has gone out and its result has come back
    task automatic drain();
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            bpr_pkg::CFG_LEARN_RATE: rate_q16   = val;
            bpr_pkg::CFG_USER_REG:   user_decay = val;
            bpr_pkg::CFG_ITEM_REG:   item_decay = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] lr, logic [15:0] ur, logic [15:0] ir);
        drain();
        write_reg(bpr_pkg::CFG_LEARN_RATE, lr);
        write_reg(bpr_pkg::CFG_USER_REG, ur);
        write_reg(bpr_pkg::CFG_ITEM_REG, ir);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            queue_cmd(random_cmd());
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_data    = '0;
        mismatches  = 0;
        idle_cycles = 0;
        gap_left    = 0;
        calm        = 1'b0;
        rate_q16    = bpr_pkg::LEARN_RATE_RST;
        user_decay  = bpr_pkg::USER_REG_RST;
        item_decay  = bpr_pkg::ITEM_REG_RST;
        build_logistic_lut();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Fill every pooled row so no read or train touches unwritten memory
        foreach (user_pool[i])
            for (int f = 0; f < N_FACT; f++)
                queue_cmd(make_cmd(bpr_pkg::ACT_WR_USER, user_pool[i], $urandom, $urandom,
                                   f, 16'($urandom_range(0, 8191) - 4096)));
        foreach (item_pool[i])
            for (int f = 0; f < N_FACT; f++)
                queue_cmd(make_cmd(bpr_pkg::ACT_WR_ITEM, $urandom, item_pool[i], $urandom,
                                   f, 16'($urandom_range(0, 8191) - 4096)));

        // Directed: field extremes, every action, unused codes, matching rows
        queue_cmd(make_cmd(bpr_pkg::ACT_WR_USER, 0, 0, 0, 0, 16'sh7fff));
        queue_cmd(make_cmd(bpr_pkg::ACT_RD_USER, 0, 4095, 4095, 0, 16'sh0));
        queue_cmd(make_cmd(bpr_pkg::ACT_WR_ITEM, 1023, 4095, 0, 15, 16'sh8000));
        queue_cmd(make_cmd(bpr_pkg::ACT_RD_ITEM, 1023, 4095, 0, 15, 16'shffff));
        queue_cmd(make_cmd(bpr_pkg::ACT_RD_USER, 1023, 0, 0, 15, 16'sh0));
        queue_cmd(make_cmd(bpr_pkg::ACT_TRAIN, 0, 0, 4095, 0, 16'sh0));
        queue_cmd(make_cmd(bpr_pkg::ACT_TRAIN, 1023, 4095, 0, 15, 16'shffff));
        queue_cmd(make_cmd(bpr_pkg::ACT_TRAIN, 341, 2730, 2730, 7, 16'sh0));
        queue_cmd(make_cmd(bpr_pkg::ACT_RD_ITEM, 341, 2730, 0, 7, 16'sh0));
        queue_cmd(make_cmd(3'(int'(bpr_pkg::ACT_TRAIN) + 1), 1023, 4095, 4095, 15,
                           16'shffff));
        queue_cmd(make_cmd(3'(int'(bpr_pkg::ACT_TRAIN) + 2), 0, 0, 0, 0, 16'sh0));
        queue_cmd(make_cmd(ACT_LAST, 682, 1365, 2730, 10, 16'sh5555));
        queue_cmd(make_cmd(bpr_pkg::ACT_TRAIN, 682, 1365, 4094, 0, 16'sh0));

        queue_random(110);
        set_regs(16'hffff, 16'hffff, 16'hffff);
        queue_random(110);
        set_regs(16'h0000, 16'h0000, 16'h0000);
        queue_random(100);
        set_regs(16'h4000, 16'h0000, 16'hffff);
        queue_random(100);
        set_regs(16'($urandom), 16'($urandom), 16'($urandom));
        queue_random(90);
        set_regs(bpr_pkg::LEARN_RATE_RST, bpr_pkg::USER_REG_RST, bpr_pkg::ITEM_REG_RST);
        queue_random(100);

        drain();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/bpr_pkg.sv
src/bpr_user_mem.sv
src/bpr_item_mem.sv
src/bpr_update_pipe.sv
src/bpr_factor_sgd_update_unit.sv
tb/sv/testbench.sv
